// ===== sv/dq_pkg.sv =====
// Shared constants, request and status codes, and the cell command struct
// for the double-ended queue. No dependencies.
`default_nettype none

package dq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int DATA_W   = 8;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 6;
  localparam int OCNT_W   = 7;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd3;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic              shift_up;    // take the lower neighbor (push front)
    logic              shift_down;  // take the upper neighbor (pop front)
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  rd_idx;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Top level of the double-ended queue: request decode, element count,
// the row of dq_cell storage cells and the result register.
// Depends on dq_pkg and dq_cell.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request kind
//   (push front, push back, pop front, pop back, read index, write index),
//   tdata carries the value and the logical position. Every request gives
//   exactly one result transaction on m_axis: the popped or read element,
//   the element count after the request, and a status (ok, overflow,
//   underflow, index out of range). A failing request leaves the queue as
//   it was; kinds 6 and 7 are ignored and report ok.
//   Elements sit in a row of cells, cell i holding logical index i. A push
//   at the front moves every element one cell up, a pop at the front one
//   cell down, all in the same cycle; the other requests touch one cell.
//   The result appears on m_axis in the cycle after acceptance, and one
//   request is taken every cycle while m_axis does not stall, as the cell
//   row and the count register are updated together.
//   When m_axis stalls, the result is held in the output register and a
//   new request is taken only in a cycle in which that result leaves.
//   Reset empties the queue (count zero) and drops any pending result; the
//   cell contents are not cleared and are never visible before written.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value[7:0], position[13:8]
  input  wire logic [KIND_W-1:0]      s_axis_tuser,   // kind[2:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // data[7:0], count[14:8]
  output logic      [STAT_W-1:0]      m_axis_tuser    // status[1:0]
);

  // Request fields.
  logic              accept;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] value;
  logic [POS_W-1:0]  position;

  assign kind     = s_axis_tuser;
  assign value    = s_axis_tdata[DATA_W-1:0];
  assign position = s_axis_tdata[DATA_W+POS_W-1:DATA_W];

  // Queue state and result register.
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [OCNT_W-1:0] res_count_q;
  logic [STAT_W-1:0] res_status_q, res_status_d;

  // Take a new request whenever the result register is empty or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic full, empty, in_range, rd_en;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign in_range = (CMP_W'(position) < CMP_W'(count_q));

  cell_cmd_t cmd;

  // Decode the request into a broadcast for the cell row.
  always_comb begin
    cmd            = '0;
    cmd.value      = value;
    count_d        = count_q;
    res_status_d   = STATUS_OK;
    rd_en          = 1'b0;
    unique case (kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          res_status_d = STATUS_OVERFLOW;
        end else begin
          cmd.shift_up = accept;
          count_d      = count_q + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          res_status_d = STATUS_OVERFLOW;
        end else begin
          cmd.wr_en  = accept;
          cmd.wr_idx = count_q[IDX_W-1:0];
          count_d    = count_q + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          res_status_d = STATUS_UNDERFLOW;
        end else begin
          cmd.shift_down = accept;
          cmd.rd_idx     = '0;
          rd_en          = 1'b1;
          count_d        = count_q - 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          res_status_d = STATUS_UNDERFLOW;
        end else begin
          cmd.rd_idx = IDX_W'(count_q - 1'b1);
          rd_en      = 1'b1;
          count_d    = count_q - 1'b1;
        end
      end
      KIND_READ: begin
        if (!in_range) begin
          res_status_d = STATUS_RANGE;
        end else begin
          cmd.rd_idx = IDX_W'(position);
          rd_en      = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (!in_range) begin
          res_status_d = STATUS_RANGE;
        end else begin
          cmd.wr_en  = accept;
          cmd.wr_idx = IDX_W'(position);
        end
      end
      default: begin
        // unused kinds: ignore
      end
    endcase
  end

  // Cell row: each cell sees its lower and upper neighbor.
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = value;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end

    dq_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .own_idx_i (IDX_W'(g)),
      .lower_i   (lower),
      .upper_i   (upper),
      .data_o    (cell_data[g]),
      .rd_data_o (cell_rd[g])
    );
  end

  // Only the addressed cell drives nonzero read data; merge them.
  always_comb begin
    res_data_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      res_data_d = res_data_d | cell_rd[i];
    end
    if (!rd_en) begin
      res_data_d = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_data_q   <= res_data_d;
      res_count_q  <= OCNT_W'(count_d);
      res_status_q <= res_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({res_count_q, res_data_q});
  assign m_axis_tuser  = res_status_q;

  // Assertions.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && full
    |=> m_axis_tuser == STATUS_OVERFLOW && count_q == $past(count_q))
    else $error("push on a full queue not flagged or state changed");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && !full
    |=> count_q == $past(count_q) + 1'b1)
    else $error("successful push did not grow the count");

  a_err_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata[DATA_W-1:0] == '0)
    else $error("failed request returned nonzero data");

endmodule

`default_nettype wire

// ===== sv/dq_cell.sv =====
// One storage cell of the deque row: holds the element at one logical index.
// Depends on dq_pkg.
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_cmd_t         cmd_i,
  input  wire logic [IDX_W-1:0]  own_idx_i,
  input  wire logic [DATA_W-1:0] lower_i,
  input  wire logic [DATA_W-1:0] upper_i,
  output logic      [DATA_W-1:0] data_o,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.shift_up) begin
      data_d = lower_i;
    end else if (cmd_i.shift_down) begin
      data_d = upper_i;
    end else if (cmd_i.wr_en && (cmd_i.wr_idx == own_idx_i)) begin
      data_d = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign rd_data_o = (cmd_i.rd_idx == own_idx_i) ? data_q : '0;

endmodule

`default_nettype wire
